FILE: rtl/core/bvt_pkg.sv
// shared types and constants for the bounded vector table
`timescale 1ns / 1ps

package bvt_pkg;

   // default sizing
   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // capacity loaded after reset, before any csr write
   localparam int INIT_CAPACITY_RESET = 8;

   // fixed field widths
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 3;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND    = 3'd0,
      CMD_READ      = 3'd1,
      CMD_WRITE     = 3'd2,
      CMD_REMOVE    = 3'd3,
      CMD_RESIZE    = 3'd4,
      CMD_READ_LAST = 3'd5
   } cmd_type;

   // result status codes
   localparam logic [STATUS_W-1:0] STS_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] STS_RANGE  = 3'd1;
   localparam logic [STATUS_W-1:0] STS_FULL   = 3'd2;
   localparam logic [STATUS_W-1:0] STS_TOOBIG = 3'd3;
   localparam logic [STATUS_W-1:0] STS_EMPTY  = 3'd4;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_READ_DATA,
      S_SHIFT_READ,
      S_SHIFT_WRITE
   } state_type;

endpackage

FILE: rtl/core/bounded_vector_table.sv
// Bounded vector table: a compact array of up to DEPTH words kept in one
// single-port memory, with an element count and a logical capacity.
// A command is taken when start is high and busy is low; its one result
// word appears on the rsp_ ports for exactly one cycle with rsp_valid high,
// and the receiver has no way to hold it off. Append, write, resize, the
// unused codes, removal of the last entry and all rejected commands are
// answered from the idle state; read and read last pass through a read-data
// state to wait for the registered memory read data. Remove moves every
// later entry down one place through the single memory port, a read and a
// write per entry, and keeps busy high until the last one is written. The
// result of a command appears in the first cycle with busy low again (or in
// the cycle after the accept for commands answered from the idle state),
// and a new command can be taken in that same cycle. A csr write resets the
// count to zero and loads the capacity, limited to 1..DEPTH.
`timescale 1ns / 1ps

module bounded_vector_table
   import bvt_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // command channel
   input  logic                           start,
   output logic                           busy,
   input  logic [CMD_W-1:0]               req_command,
   input  logic [$clog2(DEPTH)-1:0]       req_index,
   input  logic [DATA_WIDTH-1:0]          req_value,
   input  logic [$clog2(DEPTH+1)-1:0]     req_new_capacity,
   // result channel
   output logic                           rsp_valid,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic [DATA_WIDTH-1:0]          rsp_read_value,
   output logic [$clog2(DEPTH+1)-1:0]     rsp_element_count,
   output logic [$clog2(DEPTH+1)-1:0]     rsp_capacity_now,
   // configuration
   input  logic                           csr_write_enable,
   input  logic [$clog2(DEPTH+1)-1:0]     csr_write_data
);

   logic                       mem_en;
   logic                       mem_we;
   logic [$clog2(DEPTH)-1:0]   mem_addr;
   logic [DATA_WIDTH-1:0]      mem_wdata;
   logic [DATA_WIDTH-1:0]      mem_rdata;

   // command sequencer
   bvt_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_index         (req_index),
      .req_value         (req_value),
      .req_new_capacity  (req_new_capacity),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_read_value    (rsp_read_value),
      .rsp_element_count (rsp_element_count),
      .rsp_capacity_now  (rsp_capacity_now),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .mem_en            (mem_en),
      .mem_we            (mem_we),
      .mem_addr          (mem_addr),
      .mem_wdata         (mem_wdata),
      .mem_rdata         (mem_rdata)
   );

   // element store
   bvt_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock     (clock),
      .mem_en    (mem_en),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

endmodule

FILE: rtl/core/bvt_mem.sv
// single-port element store with registered read data
`timescale 1ns / 1ps

module bvt_mem
   import bvt_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         mem_en,
   input  logic                         mem_we,
   input  logic [$clog2(DEPTH)-1:0]     mem_addr,
   input  logic [DATA_WIDTH-1:0]        mem_wdata,
   output logic [DATA_WIDTH-1:0]        mem_rdata
);

   logic [DATA_WIDTH-1:0] store_mem [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   // one access per cycle, write or read
   always_ff @(posedge clock) begin
      if (mem_en) begin
         if (mem_we) begin
            store_mem[mem_addr] <= mem_wdata;
         end else begin
            rdata_ff <= store_mem[mem_addr];
         end
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

FILE: rtl/core/bvt_ctrl.sv
// command sequencer: count, capacity, memory accesses and result word
`timescale 1ns / 1ps

module bvt_ctrl
   import bvt_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // command channel
   input  logic                           start,
   output logic                           busy,
   input  logic [CMD_W-1:0]               req_command,
   input  logic [$clog2(DEPTH)-1:0]       req_index,
   input  logic [DATA_WIDTH-1:0]          req_value,
   input  logic [$clog2(DEPTH+1)-1:0]     req_new_capacity,
   // result channel
   output logic                           rsp_valid,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic [DATA_WIDTH-1:0]          rsp_read_value,
   output logic [$clog2(DEPTH+1)-1:0]     rsp_element_count,
   output logic [$clog2(DEPTH+1)-1:0]     rsp_capacity_now,
   // configuration
   input  logic                           csr_write_enable,
   input  logic [$clog2(DEPTH+1)-1:0]     csr_write_data,
   // memory port
   output logic                           mem_en,
   output logic                           mem_we,
   output logic [$clog2(DEPTH)-1:0]       mem_addr,
   output logic [DATA_WIDTH-1:0]          mem_wdata,
   input  logic [DATA_WIDTH-1:0]          mem_rdata
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CAP_RESET =
      CNT_W'((INIT_CAPACITY_RESET > DEPTH) ? DEPTH : INIT_CAPACITY_RESET);

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        capacity_ff, capacity_in;
   logic [IDX_W-1:0]        ptr_ff, ptr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [DATA_WIDTH-1:0]   rsp_read_value_ff, rsp_read_value_in;

   logic [CNT_W:0]          cap_doubled;
   logic [CNT_W-1:0]        index_ext;
   logic [CNT_W-1:0]        index_next;
   logic [CNT_W-1:0]        ptr_next;

   assign cap_doubled = {capacity_ff, 1'b0};
   assign index_ext   = CNT_W'(req_index);
   assign index_next  = index_ext + CNT_W'(1);
   assign ptr_next    = CNT_W'(ptr_ff) + CNT_W'(1);

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff            <= ptr_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_read_value_ff <= rsp_read_value_in;
   end

   // next state, memory access and result word
   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      capacity_in       = capacity_ff;
      ptr_in            = ptr_ff;
      rsp_valid_in      = 1'b0;
      rsp_status_in     = rsp_status_ff;
      rsp_read_value_in = rsp_read_value_ff;
      mem_en            = 1'b0;
      mem_we            = 1'b0;
      mem_addr          = '0;
      mem_wdata         = req_value;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_status_in     = STS_OK;
               rsp_read_value_in = '0;
               case (cmd_type'(req_command))
                  CMD_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= capacity_ff && cap_doubled > {1'b0, DEPTH_C}) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        if (count_ff >= capacity_ff) begin
                           capacity_in = cap_doubled[CNT_W-1:0];
                        end
                        if (count_ff < DEPTH_C) begin
                           mem_en   = 1'b1;
                           mem_we   = 1'b1;
                           mem_addr = IDX_W'(count_ff);
                           count_in = count_ff + CNT_W'(1);
                        end else begin
                           rsp_status_in = STS_FULL;
                        end
                     end
                  end
                  CMD_READ: begin
                     if (index_ext >= count_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_RANGE;
                     end else begin
                        mem_en   = 1'b1;
                        mem_addr = req_index;
                        state_in = S_READ_DATA;
                     end
                  end
                  CMD_WRITE: begin
                     rsp_valid_in = 1'b1;
                     if (index_ext >= count_ff) begin
                        rsp_status_in = STS_RANGE;
                     end else begin
                        mem_en   = 1'b1;
                        mem_we   = 1'b1;
                        mem_addr = req_index;
                     end
                  end
                  CMD_REMOVE: begin
                     if (index_ext >= count_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_RANGE;
                     end else if (index_next < count_ff) begin
                        // fetch the first entry that moves down
                        mem_en   = 1'b1;
                        mem_addr = IDX_W'(index_next);
                        ptr_in   = IDX_W'(index_next);
                        state_in = S_SHIFT_WRITE;
                     end else begin
                        // removing the last entry needs no shift
                        rsp_valid_in = 1'b1;
                        count_in     = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_RESIZE: begin
                     rsp_valid_in = 1'b1;
                     if (req_new_capacity == '0 || req_new_capacity > DEPTH_C) begin
                        rsp_status_in = STS_TOOBIG;
                     end else begin
                        capacity_in = req_new_capacity;
                        if (count_ff > req_new_capacity) begin
                           count_in = req_new_capacity;
                        end
                     end
                  end
                  CMD_READ_LAST: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        mem_en   = 1'b1;
                        mem_addr = IDX_W'(count_ff - CNT_W'(1));
                        state_in = S_READ_DATA;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ_DATA: begin
            rsp_valid_in      = 1'b1;
            rsp_status_in     = STS_OK;
            rsp_read_value_in = mem_rdata;
            state_in          = S_IDLE;
         end
         S_SHIFT_WRITE: begin
            // move the fetched word one place down
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = ptr_ff - IDX_W'(1);
            mem_wdata = mem_rdata;
            if (ptr_next < count_ff) begin
               ptr_in   = IDX_W'(ptr_next);
               state_in = S_SHIFT_READ;
            end else begin
               count_in     = count_ff - CNT_W'(1);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SHIFT_READ: begin
            mem_en   = 1'b1;
            mem_addr = ptr_ff;
            state_in = S_SHIFT_WRITE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // csr write re-initializes the table
      if (csr_write_enable) begin
         count_in = '0;
         if (csr_write_data == '0) begin
            capacity_in = CNT_W'(1);
         end else if (csr_write_data > DEPTH_C) begin
            capacity_in = DEPTH_C;
         end else begin
            capacity_in = csr_write_data;
         end
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_read_value    = rsp_read_value_ff;
   assign rsp_element_count = count_ff;
   assign rsp_capacity_now  = capacity_ff;

endmodule
